FILE: sv/itp_pkg.sv
// Shared types, constants and character helpers for the infix to postfix converter.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] CH_POW    = 8'h5E;
  localparam logic [SYM_W-1:0] CH_MUL    = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV    = 8'h2F;
  localparam logic [SYM_W-1:0] CH_ADD    = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB    = 8'h2D;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

  typedef enum logic [1:0] {
    KIND_SYM = 2'd0,
    KIND_END = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CHAR  = 2'd1,
    ERR_PAREN = 2'd2,
    ERR_OVER  = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    PUT_IN,
    PUT_TOP,
    PUT_END,
    PUT_ERR
  } put_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OP_RD,
    ST_OP_EX,
    ST_OP_PUSH,
    ST_UN_RD,
    ST_UN_EX,
    ST_CHK_LAST,
    ST_ERR,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    logic      push;
    logic      pop;
    logic      clr_level;
    logic      set_disc;
    logic      clr_disc;
    logic      put_en;
    put_sel_t  put_sel;
    err_code_t err;
    logic      flush;
  } itp_cmd_t;

  typedef struct packed {
    logic disc;
    logic last;
    logic is_lparen;
    logic is_rparen;
    logic is_alnum;
    logic is_op;
    logic level_zero;
    logic level_full;
    logic top_lparen;
    logic top_pops;
    logic slot_ok;
    logic flush_ok;
  } itp_status_t;

  function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_POW) p = 2'd3;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_ADD || c == CH_SUB) p = 2'd1;
    return p;
  endfunction

  function automatic logic is_alnum_char(input logic [SYM_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage
`default_nettype wire

FILE: sv/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix to postfix converter.
//
// Input channel in_*: one ASCII character per word in in_tdata[7:0], in_tlast
// marks the final character of an expression. The block takes one word at a
// time; in_tready is high only while no word is being worked on.
// Output channel out_*: one result per word. out_tuser holds the kind (symbol,
// expression finished, error), out_tdata[7:0] the postfix symbol and
// out_tdata[9:8] the error code. out_tlast marks the final result caused by
// one input word.
// Each operator popped from the stack goes through the registered read of the
// stack RAM (issue read, then examine and pop); the push, the final unwind and
// the error or end result are further steps of their own.
// Results pass through a one-deep pending stage and an output register, so the
// last result of a word is known before it leaves.
// Reset clears the stack level, the discard flag and both valid flags; the
// stack contents need no clearing. When the receiver stalls, the output
// register holds and the work waits once the pending stage is also full.
`default_nettype none
module infix_to_postfix_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_symbol, [9:8] error_code
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // end_of_run
);
  import itp_pkg::*;

  itp_cmd_t         cmd;
  itp_status_t      st;
  logic [SYM_W-1:0] res_sym;
  kind_t            res_kind;
  err_code_t        res_err;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  itp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_symbol (in_tdata),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_symbol(res_sym),
    .out_kind  (res_kind),
    .out_err   (res_err),
    .out_eor   (out_tlast)
  );

  assign out_tdata = {6'b0, res_err, res_sym};
  assign out_tuser = res_kind;

endmodule
`default_nettype wire

FILE: sv/itp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module itp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/itp_ctrl.sv
// Controller state machine sequencing decode, stack pops, pushes and result flush.
`default_nettype none
module itp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire itp_pkg::itp_status_t st,
  output itp_pkg::itp_cmd_t        cmd
);
  import itp_pkg::*;

  state_t    state_r, state_nxt;
  err_code_t err_r, err_nxt;
  logic      final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= ERR_NONE;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    final_nxt = final_r;
    cmd       = '0;
    cmd.put_sel = PUT_IN;
    cmd.err     = ERR_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        final_nxt = 1'b0;
        if (st.disc) begin
          if (st.last) begin
            cmd.clr_disc  = 1'b1;
            cmd.clr_level = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else if (st.is_lparen) begin
          if (st.level_full) begin
            err_nxt   = ERR_OVER;
            state_nxt = ST_ERR;
          end else begin
            cmd.push  = 1'b1;
            state_nxt = ST_CHK_LAST;
          end
        end else if (st.is_alnum) begin
          if (st.slot_ok) begin
            cmd.put_en  = 1'b1;
            cmd.put_sel = PUT_IN;
            state_nxt   = ST_CHK_LAST;
          end
        end else if (st.is_op) begin
          state_nxt = ST_OP_RD;
        end else if (st.is_rparen) begin
          state_nxt = ST_UN_RD;
        end else begin
          err_nxt   = ERR_CHAR;
          state_nxt = ST_ERR;
        end
      end
      ST_OP_RD: begin
        if (st.level_zero) begin
          state_nxt = ST_OP_PUSH;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_OP_EX;
        end
      end
      ST_OP_EX: begin
        if (!st.top_pops) begin
          state_nxt = ST_OP_PUSH;
        end else if (st.slot_ok) begin
          cmd.put_en  = 1'b1;
          cmd.put_sel = PUT_TOP;
          cmd.pop     = 1'b1;
          state_nxt   = ST_OP_RD;
        end
      end
      ST_OP_PUSH: begin
        if (st.level_full) begin
          err_nxt   = ERR_OVER;
          state_nxt = ST_ERR;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = ST_CHK_LAST;
        end
      end
      ST_UN_RD: begin
        if (st.level_zero) begin
          if (final_r) begin
            if (st.slot_ok) begin
              cmd.put_en    = 1'b1;
              cmd.put_sel   = PUT_END;
              cmd.clr_level = 1'b1;
              state_nxt     = ST_FLUSH;
            end
          end else begin
            err_nxt   = ERR_PAREN;
            state_nxt = ST_ERR;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_UN_EX;
        end
      end
      ST_UN_EX: begin
        if (st.top_lparen) begin
          cmd.pop = 1'b1;
          if (final_r) begin
            err_nxt   = ERR_PAREN;
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_CHK_LAST;
          end
        end else if (st.slot_ok) begin
          cmd.put_en  = 1'b1;
          cmd.put_sel = PUT_TOP;
          cmd.pop     = 1'b1;
          state_nxt   = ST_UN_RD;
        end
      end
      ST_CHK_LAST: begin
        if (st.last) begin
          final_nxt = 1'b1;
          state_nxt = ST_UN_RD;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_ERR: begin
        if (st.slot_ok) begin
          cmd.put_en    = 1'b1;
          cmd.put_sel   = PUT_ERR;
          cmd.err       = err_r;
          cmd.clr_level = 1'b1;
          cmd.set_disc  = !st.last;
          state_nxt     = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (st.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/itp_dpath.sv
// Datapath: input word, operator stack, stack level, pending result and output register.
`default_nettype none
module itp_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire itp_pkg::itp_cmd_t          cmd,
  output itp_pkg::itp_status_t            st,
  input  wire logic [itp_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [itp_pkg::SYM_W-1:0]       out_symbol,
  output itp_pkg::kind_t                  out_kind,
  output itp_pkg::err_code_t              out_err,
  output logic                            out_eor
);
  import itp_pkg::*;

  logic [SYM_W-1:0]   sym_r;
  logic               last_r;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               disc_r, disc_nxt;

  logic [SYM_W-1:0]   pend_sym_r;
  kind_t              pend_kind_r;
  err_code_t          pend_err_r;
  logic               pend_v_r, pend_v_nxt;

  logic [SYM_W-1:0]   out_sym_r;
  kind_t              out_kind_r;
  err_code_t          out_err_r;
  logic               out_eor_r;
  logic               out_v_r, out_v_nxt;

  logic [LEVEL_W-1:0] level_m1;
  logic [SYM_W-1:0]   top;
  logic               out_free;
  logic               move_out;

  assign level_m1 = level_r - LEVEL_W'(1);

  itp_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_stack (
    .clk    (clk),
    .wr_en  (cmd.push),
    .wr_addr(level_r[ADDR_W-1:0]),
    .wr_data(sym_r),
    .rd_en  (cmd.rd_en),
    .rd_addr(level_m1[ADDR_W-1:0]),
    .rd_data(top)
  );

  assign out_free = !out_v_r || out_ready;
  assign move_out = pend_v_r && ((cmd.put_en) || cmd.flush);

  always_comb begin
    st            = '0;
    st.disc       = disc_r;
    st.last       = last_r;
    st.is_lparen  = (sym_r == CH_LPAREN);
    st.is_rparen  = (sym_r == CH_RPAREN);
    st.is_alnum   = is_alnum_char(sym_r);
    st.is_op      = (prec_of(sym_r) != 2'd0);
    st.level_zero = (level_r == '0);
    st.level_full = (level_r == LEVEL_W'(STACK_DEPTH));
    st.top_lparen = (top == CH_LPAREN);
    st.top_pops   = (prec_of(top) != 2'd0) && (prec_of(top) >= prec_of(sym_r));
    st.slot_ok    = !pend_v_r || out_free;
    st.flush_ok   = !pend_v_r || out_free;
  end

  always_comb begin
    level_nxt = level_r;
    if (cmd.clr_level) level_nxt = '0;
    else if (cmd.push) level_nxt = level_r + LEVEL_W'(1);
    else if (cmd.pop)  level_nxt = level_m1;

    disc_nxt = disc_r;
    if (cmd.set_disc)      disc_nxt = 1'b1;
    else if (cmd.clr_disc) disc_nxt = 1'b0;

    pend_v_nxt = pend_v_r;
    if (cmd.put_en)     pend_v_nxt = 1'b1;
    else if (cmd.flush) pend_v_nxt = 1'b0;

    out_v_nxt = out_v_r && !out_ready;
    if (move_out) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      disc_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      disc_r   <= disc_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (move_out) begin
      out_sym_r  <= pend_sym_r;
      out_kind_r <= pend_kind_r;
      out_err_r  <= pend_err_r;
      out_eor_r  <= cmd.flush;
    end
    if (cmd.put_en) begin
      case (cmd.put_sel)
        PUT_IN: begin
          pend_sym_r  <= sym_r;
          pend_kind_r <= KIND_SYM;
          pend_err_r  <= ERR_NONE;
        end
        PUT_TOP: begin
          pend_sym_r  <= top;
          pend_kind_r <= KIND_SYM;
          pend_err_r  <= ERR_NONE;
        end
        PUT_END: begin
          pend_sym_r  <= '0;
          pend_kind_r <= KIND_END;
          pend_err_r  <= ERR_NONE;
        end
        default: begin
          pend_sym_r  <= '0;
          pend_kind_r <= KIND_ERR;
          pend_err_r  <= cmd.err;
        end
      endcase
    end
  end

  assign out_valid  = out_v_r;
  assign out_symbol = out_sym_r;
  assign out_kind   = out_kind_r;
  assign out_err    = out_err_r;
  assign out_eor    = out_eor_r;

endmodule
`default_nettype wire

FILE: sv/itp_checker.sv
// Port-level checker for the infix to postfix converter, bound to the top level.
`default_nettype none
module itp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);
  import itp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_sym_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SYM |-> out_tdata[9:8] == ERR_NONE)
    else $error("symbol result carries an error code");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_ERR) |->
      out_tlast && out_tdata[7:0] == 8'h00)
    else $error("end or error result not final or carries a symbol");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR |-> out_tdata[9:8] != ERR_NONE)
    else $error("error result without an error code");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
`default_nettype wire
